// ----- hdl/rar_pkg.sv -----
// rar_pkg: shared constants, codes and control types of the rational arithmetic unit
// no dependencies; used by rar_mult, rar_engine and rational_arith_reduce_unit
package rar_pkg;

    // default operand width of one fraction term
    localparam int DEF_OPERAND_WIDTH = 16;

    // result field widths
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;
    localparam int M_TDATA_W = RES_NUM_W + RES_DEN_W;
    localparam int FUNC_W    = 2;

    // operand slots inside s_tdata, lowest first
    localparam int FLD_AN   = 0;
    localparam int FLD_AD   = 1;
    localparam int FLD_BN   = 2;
    localparam int FLD_BD   = 3;
    localparam int N_FIELDS = 4;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // engine job kinds
    typedef enum logic {
        ENG_GCD = 1'b0,
        ENG_DIV = 1'b1
    } eng_mode_t;

    // sequencer to engine
    typedef struct packed {
        logic      start;
        eng_mode_t mode;
    } eng_ctrl_t;

    // engine to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

endpackage

// ----- hdl/rational_arith_reduce_unit.sv -----
// rational_arith_reduce_unit: top level, fraction add/sub/mul/div reduced to lowest terms
// depends on rar_pkg, rar_mult and rar_engine
// sequence: the multiply steps, the sum step, the gcd loop (shifts and subtracts on the two 2W-bit
//   terms, then the shift-back) and two divisions on one subtractor; a zero denominator skips the
//   gcd and both divisions
// throughput: one item at a time; s_tready returns when the result is loaded into the output register
// reset: aresetn synchronous active low, clears the sequencer, engine and output valid
module rational_arith_reduce_unit #(
    parameter int OPERAND_WIDTH = rar_pkg::DEF_OPERAND_WIDTH,
    localparam int S_TDATA_W = ((rar_pkg::N_FIELDS * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_num, a_den, b_num, b_den (each OPERAND_WIDTH, signed), then zero fill
    input  logic [S_TDATA_W-1:0]          s_tdata,
    // func
    input  logic [rar_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // res_num (33, signed), res_den (31)
    output logic [rar_pkg::M_TDATA_W-1:0] m_tdata,
    // zero_den_error
    output logic [0:0]                    m_tuser
);

    localparam int W   = OPERAND_WIDTH;
    localparam int MW  = 2 * W;
    localparam int NXW = (MW + 1 > rar_pkg::RES_NUM_W) ? MW + 1 : rar_pkg::RES_NUM_W;
    localparam int DXW = (MW > rar_pkg::RES_DEN_W) ? MW : rar_pkg::RES_DEN_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIVN = 7'b0010000,
        S_DIVD = 7'b0100000,
        S_OUT  = 7'b1000000
    } seq_state_t;

    seq_state_t            state_reg, state_next;
    logic [1:0]            mul_cnt_reg, mul_cnt_next;
    rar_pkg::func_t        func_reg;
    logic [W-1:0]          mag_reg [rar_pkg::N_FIELDS];
    logic                  neg_reg [rar_pkg::N_FIELDS];
    logic [MW-1:0]         p_reg   [3];
    logic [MW-1:0]         num_mag_reg, num_mag_next;
    logic                  num_neg_reg, num_neg_next;
    logic [MW-1:0]         den_mag_reg;
    logic                  den_neg_reg, den_neg_next;
    logic                  err_reg, err_next;
    logic [MW-1:0]         g_reg, nm_reg, dm_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [rar_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic [W-1:0]          fld     [rar_pkg::N_FIELDS];
    logic [W-1:0]          fld_mag [rar_pkg::N_FIELDS];
    logic                  s_accept;
    logic                  out_free;

    logic [W-1:0]          mul_a, mul_b;
    logic [MW-1:0]         prod;

    rar_pkg::eng_ctrl_t    eng_ctrl;
    rar_pkg::eng_status_t  eng_status;
    logic [MW-1:0]         eng_a, eng_b, eng_result;

    logic                  sa, sb, sd;
    logic                  res_neg;
    logic signed [MW:0]    nres;
    logic signed [NXW-1:0] num_x;
    logic [DXW-1:0]        den_x;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // operand fields and their magnitudes
    always_comb begin
        for (int i = 0; i < rar_pkg::N_FIELDS; i++) begin
            fld[i]     = s_tdata[i*W +: W];
            fld_mag[i] = fld[i][W-1] ? (W'(0) - fld[i]) : fld[i];
        end
    end

    // multiplier operand select per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mul_cnt_reg)
            2'd0: begin
                mul_a = mag_reg[rar_pkg::FLD_AN];
                mul_b = (func_reg == rar_pkg::FUNC_MUL) ? mag_reg[rar_pkg::FLD_BN]
                                                        : mag_reg[rar_pkg::FLD_BD];
            end
            2'd1: begin
                if (func_reg == rar_pkg::FUNC_ADD || func_reg == rar_pkg::FUNC_SUB) begin
                    mul_a = mag_reg[rar_pkg::FLD_AD];
                    mul_b = mag_reg[rar_pkg::FLD_BN];
                end
            end
            2'd2: begin
                mul_a = mag_reg[rar_pkg::FLD_AD];
                mul_b = (func_reg == rar_pkg::FUNC_DIV) ? mag_reg[rar_pkg::FLD_BN]
                                                        : mag_reg[rar_pkg::FLD_BD];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rar_mult #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // raw signs of the three products
    always_comb begin
        sa = neg_reg[rar_pkg::FLD_AN] ^ ((func_reg == rar_pkg::FUNC_MUL) ?
                                          neg_reg[rar_pkg::FLD_BN] : neg_reg[rar_pkg::FLD_BD]);
        sb = neg_reg[rar_pkg::FLD_AD] ^ neg_reg[rar_pkg::FLD_BN] ^
             (func_reg == rar_pkg::FUNC_SUB);
        sd = neg_reg[rar_pkg::FLD_AD] ^ ((func_reg == rar_pkg::FUNC_DIV) ?
                                          neg_reg[rar_pkg::FLD_BN] : neg_reg[rar_pkg::FLD_BD]);
    end

    // signed sum of the two numerator products
    always_comb begin
        if (sa == sb) begin
            num_mag_next = p_reg[0] + p_reg[1];
            num_neg_next = sa;
        end else if (p_reg[0] >= p_reg[1]) begin
            num_mag_next = p_reg[0] - p_reg[1];
            num_neg_next = sa;
        end else begin
            num_mag_next = p_reg[1] - p_reg[0];
            num_neg_next = sb;
        end
        if (num_mag_next == '0) begin
            num_neg_next = 1'b0;
        end
        den_neg_next = sd;
        err_next     = (p_reg[2] == '0);
    end

    // reduced result with sign, masked to the output fields
    always_comb begin
        res_neg = (nm_reg != '0) && (num_neg_reg != den_neg_reg);
        nres    = res_neg ? ((MW+1)'(0) - {1'b0, nm_reg}) : {1'b0, nm_reg};
        num_x   = NXW'(nres);
        den_x   = DXW'(dm_reg);
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        mul_cnt_next  = mul_cnt_reg;
        eng_ctrl      = '{start: 1'b0, mode: rar_pkg::ENG_GCD};
        eng_a         = num_mag_reg;
        eng_b         = eng_result;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    mul_cnt_next = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL: begin
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (err_next) begin
                    state_next = S_OUT;
                end else begin
                    eng_ctrl   = '{start: 1'b1, mode: rar_pkg::ENG_GCD};
                    eng_a      = num_mag_next;
                    eng_b      = p_reg[2];
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (eng_status.done) begin
                    eng_ctrl   = '{start: 1'b1, mode: rar_pkg::ENG_DIV};
                    eng_a      = num_mag_reg;
                    eng_b      = eng_result;
                    state_next = S_DIVN;
                end
            end
            S_DIVN: begin
                if (eng_status.done) begin
                    eng_ctrl   = '{start: 1'b1, mode: rar_pkg::ENG_DIV};
                    eng_a      = den_mag_reg;
                    eng_b      = g_reg;
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                if (eng_status.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = err_reg;
                    if (err_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {den_x[rar_pkg::RES_DEN_W-1:0],
                                        num_x[rar_pkg::RES_NUM_W-1:0]};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    rar_engine #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (eng_ctrl),
        .op_a    (eng_a),
        .op_b    (eng_b),
        .status  (eng_status),
        .result  (eng_result)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mul_cnt_reg <= mul_cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (s_accept) begin
            func_reg <= rar_pkg::func_t'(s_tuser);
            for (int i = 0; i < rar_pkg::N_FIELDS; i++) begin
                mag_reg[i] <= fld_mag[i];
                neg_reg[i] <= fld[i][W-1];
            end
        end
        if (state_reg == S_MUL && mul_cnt_reg != 2'd0) begin
            p_reg[mul_cnt_reg - 2'd1] <= prod;
        end
        if (state_reg == S_SUM) begin
            num_mag_reg <= num_mag_next;
            num_neg_reg <= num_neg_next;
            den_mag_reg <= p_reg[2];
            den_neg_reg <= den_neg_next;
            err_reg     <= err_next;
        end
        if (eng_status.done) begin
            if (state_reg == S_GCD) begin
                g_reg <= eng_result;
            end
            if (state_reg == S_DIVN) begin
                nm_reg <= eng_result;
            end
            if (state_reg == S_DIVD) begin
                dm_reg <= eng_result;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an error result carries 0/0
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error result with nonzero fields");

    // a good result has a nonzero denominator
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[rar_pkg::M_TDATA_W-1:rar_pkg::RES_NUM_W] != '0)
        else $error("zero denominator without error flag");

    // busy right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready while an item is in work");

    // engine jobs are only issued to an idle engine
    a_engine_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_ctrl.start |-> !eng_status.busy)
        else $error("engine started while busy");

endmodule

// ----- hdl/rar_mult.sv -----
// rar_mult: shared unsigned magnitude multiplier with a registered product
// depends on rar_pkg for the default operand width
module rar_mult #(
    parameter int OPERAND_WIDTH = rar_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                       aclk,
    input  logic [OPERAND_WIDTH-1:0]   mul_a,
    input  logic [OPERAND_WIDTH-1:0]   mul_b,
    output logic [2*OPERAND_WIDTH-1:0] prod
);

    localparam int MW = 2 * OPERAND_WIDTH;

    logic [MW-1:0] prod_reg;
    logic [MW-1:0] prod_next;

    // full-width product of two magnitudes
    assign prod_next = MW'(mul_a) * MW'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/rar_engine.sv -----
// rar_engine: iterative gcd (binary, shift and subtract) and restoring divider
// both jobs share one subtractor; depends on rar_pkg for control types
module rar_engine #(
    parameter int OPERAND_WIDTH = rar_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rar_pkg::eng_ctrl_t          ctrl,
    input  logic [2*OPERAND_WIDTH-1:0]  op_a,
    input  logic [2*OPERAND_WIDTH-1:0]  op_b,
    output rar_pkg::eng_status_t        status,
    output logic [2*OPERAND_WIDTH-1:0]  result
);

    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int SW = MW + 2;
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_GCD  = 4'b0010,
        E_SHL  = 4'b0100,
        E_DIV  = 4'b1000
    } eng_phase_t;

    eng_phase_t        phase_reg, phase_next;
    logic              done_reg, done_next;
    rar_pkg::eng_mode_t mode_reg, mode_next;
    logic [MW-1:0]     x_reg, x_next;
    logic [MW-1:0]     y_reg, y_next;
    logic [MW-1:0]     d_reg, d_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic [MW:0]       rs;
    logic [SW-1:0]     sub_a, sub_b, diff;
    logic              borrow;

    // shared subtractor: x - y for gcd, partial remainder - divisor for division
    always_comb begin
        rs = {y_reg, x_reg[MW-1]};
        if (phase_reg == E_DIV) begin
            sub_a = SW'(rs);
            sub_b = SW'(d_reg);
        end else begin
            sub_a = SW'(x_reg);
            sub_b = SW'(y_reg);
        end
        diff   = sub_a - sub_b;
        borrow = diff[SW-1];
    end

    // step sequencing
    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        mode_next  = mode_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        case (phase_reg)
            E_IDLE: begin
                if (ctrl.start) begin
                    mode_next = ctrl.mode;
                    x_next    = op_a;
                    if (ctrl.mode == rar_pkg::ENG_GCD) begin
                        y_next     = op_b;
                        k_next     = '0;
                        phase_next = E_GCD;
                    end else begin
                        y_next     = '0;
                        d_next     = op_b;
                        cnt_next   = '0;
                        phase_next = E_DIV;
                    end
                end
            end
            E_GCD: begin
                if (x_reg == '0) begin
                    phase_next = E_SHL;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    // common factor of two
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (!borrow) begin
                    x_next = diff[MW-1:0];
                end else begin
                    // both odd and x below y: swap so the next subtract stays positive
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            E_SHL: begin
                // put back the common powers of two
                if (k_reg == '0) begin
                    done_next  = 1'b1;
                    phase_next = E_IDLE;
                end else begin
                    y_next = y_reg << 1;
                    k_next = k_reg - KW'(1);
                end
            end
            E_DIV: begin
                y_next = borrow ? rs[MW-1:0] : diff[MW-1:0];
                x_next = {x_reg[MW-2:0], ~borrow};
                if (cnt_reg == CW'(MW - 1)) begin
                    done_next  = 1'b1;
                    phase_next = E_IDLE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default: begin
                phase_next = E_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        d_reg    <= d_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
    end

    assign status.busy = (phase_reg != E_IDLE);
    assign status.done = done_reg;
    assign result      = (mode_reg == rar_pkg::ENG_DIV) ? x_reg : y_reg;

endmodule
